// ===== src/nrte_pkg.sv =====
package nrte_pkg;

    localparam int POS_W    = 7;
    localparam int STATUS_W = 5;
    localparam int BCD_W    = 24;
    localparam int LATE_W   = 12;

    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 5'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DOLLAR   = 5'd1;
    localparam logic [STATUS_W-1:0] ST_HEADER      = 5'd2;
    localparam logic [STATUS_W-1:0] ST_TIME        = 5'd3;
    localparam logic [STATUS_W-1:0] ST_PREFIX_BASE = 5'd4;
    localparam logic [STATUS_W-1:0] ST_COMMA_BASE  = 5'd9;
    localparam logic [STATUS_W-1:0] ST_LAST        = 5'd20;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Layout: end of header, time, prefix; date span
    localparam logic [POS_W-1:0] HDR_END    = 7'd6;
    localparam logic [POS_W-1:0] TIME_END   = 7'd12;
    localparam logic [POS_W-1:0] PREFIX_BEG = 7'd13;
    localparam logic [POS_W-1:0] PREFIX_END = 7'd17;
    localparam logic [POS_W-1:0] DATE_BEG   = 7'd58;
    localparam logic [POS_W-1:0] DATE_END   = 7'd63;
    localparam int               DATE_BIT   = 11;
    localparam int               N_COMMA    = 7;
    localparam int               N_DOT      = 4;

    // Padded to eight entries so a 3-bit index never runs off the end
    localparam logic [7:0] HEADER_CHARS [8] = '{
        8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C, 8'h00};
    localparam logic [7:0] PREFIX_CHARS [8] = '{
        8'h2E, 8'h30, 8'h2C, 8'h41, 8'h2C, 8'h00, 8'h00, 8'h00};
    localparam logic [POS_W-1:0] COMMA_POS [N_COMMA] = '{
        7'd28, 7'd30, 7'd42, 7'd44, 7'd57, 7'd64, 7'd70};
    localparam logic [POS_W-1:0] DOT_POS [N_DOT] = '{
        7'd22, 7'd36, 7'd55, 7'd68};

    typedef struct packed {
        logic                 dollar_seen;
        logic [POS_W-1:0]     char_position;
        logic [STATUS_W-1:0]  early_error;
        logic [LATE_W-1:0]    late_fail_mask;
        logic [BCD_W-1:0]     time_digits;
        logic [BCD_W-1:0]     date_digits;
    } nrte_state_t;

    localparam nrte_state_t STATE_INIT = '{
        dollar_seen:    1'b0,
        char_position:  '0,
        early_error:    ST_OK,
        late_fail_mask: '1,
        time_digits:    '0,
        date_digits:    '0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Digit value, or 0xF for anything else
    function automatic logic [3:0] digit_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return is_digit(c) ? d[3:0] : 4'hF;
    endfunction

    // Code of the first early check at a position (0..17)
    function automatic logic [STATUS_W-1:0] early_code(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] d;
        d = pos - 7'd9;
        if (pos <= HDR_END) begin
            return ST_HEADER;
        end else if (pos <= TIME_END) begin
            return ST_TIME;
        end
        return d[STATUS_W-1:0];
    endfunction

endpackage

// ===== src/nrte_step.sv =====
module nrte_step
    import nrte_pkg::*;
(
    input  nrte_state_t          cur,
    input  logic [7:0]           char_in,
    output nrte_state_t          nxt,
    output logic [STATUS_W-1:0]  status
);

    logic             do_check;
    logic             ok;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pre_idx;
    logic [STATUS_W-1:0] late_code;
    logic             date_ok;

    assign pre_idx = pos - PREFIX_BEG;

    always_comb begin
        nxt      = cur;
        do_check = 1'b0;
        pos      = '0;
        ok       = 1'b1;
        date_ok  = 1'b1;

        if (!cur.dollar_seen) begin
            if (cur.early_error == ST_OK) begin
                if (char_in == CH_DOLLAR) begin
                    nxt.dollar_seen   = 1'b1;
                    nxt.char_position = '0;
                    do_check          = 1'b1;
                end else if (char_in == CH_NUL) begin
                    nxt.early_error = ST_NO_DOLLAR;
                end
            end
        end else begin
            pos = (cur.char_position == POS_MAX) ? POS_MAX : cur.char_position + 7'd1;
            nxt.char_position = pos;
            do_check          = 1'b1;
        end

        if (do_check) begin
            if (pos <= HDR_END) begin
                ok = (char_in == HEADER_CHARS[pos[2:0]]);
            end else if (pos <= TIME_END) begin
                ok = is_digit(char_in);
                nxt.time_digits = {cur.time_digits[BCD_W-5:0], digit_nibble(char_in)};
            end else if (pos <= PREFIX_END) begin
                ok = (char_in == PREFIX_CHARS[pre_idx[2:0]]);
            end
            if (!ok && cur.early_error == ST_OK) begin
                nxt.early_error = early_code(pos);
            end

            for (int i = 0; i < N_COMMA; i++) begin
                if (pos == COMMA_POS[i]) begin
                    nxt.late_fail_mask[i] = (char_in != CH_COMMA);
                end
            end
            for (int i = 0; i < N_DOT; i++) begin
                if (pos == DOT_POS[i]) begin
                    nxt.late_fail_mask[N_COMMA+i] = (char_in != CH_DOT);
                end
            end

            if (pos >= DATE_BEG && pos <= DATE_END) begin
                nxt.date_digits = {cur.date_digits[BCD_W-5:0], digit_nibble(char_in)};
                if (pos == DATE_END) begin
                    // non-digits are held as 0xF, so any nibble above 9 fails
                    for (int i = 0; i < BCD_W/4; i++) begin
                        if (nxt.date_digits[4*i +: 4] > 4'd9) begin
                            date_ok = 1'b0;
                        end
                    end
                    nxt.late_fail_mask[DATE_BIT] = !date_ok;
                end
            end
        end
    end

    // Lowest failed late check wins
    always_comb begin
        late_code = ST_OK;
        for (int i = LATE_W - 1; i >= 0; i--) begin
            if (nxt.late_fail_mask[i]) begin
                late_code = ST_COMMA_BASE + STATUS_W'(i);
            end
        end
    end

    always_comb begin
        if (!nxt.dollar_seen) begin
            status = ST_NO_DOLLAR;
        end else if (nxt.early_error != ST_OK) begin
            status = nxt.early_error;
        end else if (nxt.char_position < PREFIX_END) begin
            status = early_code(nxt.char_position + 7'd1);
        end else begin
            status = late_code;
        end
    end

endmodule

// ===== src/nmea_rmc_time_extractor_core.sv =====
// Channel | Dir | tdata (low bit up)                          | tlast
// s_      | in  | line_byte[7:0]                              | line_last
// m_      | out | status[4:0], time_bcd[28:5], date_bcd[52:29] | -
//
// One byte per cycle sustained, except while a last byte waits on a stalled m_ side.
// Each byte goes through an input register, then one pass of position compares
// that updates the line state and, on the last byte, loads the result register.
// The state returns to its initial value after the last byte of a line.
// aresetn (synchronous) clears valid flags and line state; data registers keep theirs.
// A stalled m_ side holds the pending result; bytes without tlast keep flowing.
module nmea_rmc_time_extractor_core
    import nrte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // line_byte[7:0]
    input  logic        s_tlast,   // line_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[4:0], time_bcd[28:5], date_bcd[52:29], zero pad
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    nrte_state_t state_reg;
    nrte_state_t state_next;
    logic [STATUS_W-1:0] status_next;
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic        advance;
    logic        result_ok;

    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign result_ok = (status_next == ST_OK);

    nrte_step u_step (
        .cur     (state_reg),
        .char_in (in_byte_reg),
        .nxt     (state_next),
        .status  (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_INIT;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= in_last_reg ? STATE_INIT : state_next;
            end
            if (advance && in_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= {3'b000,
                           result_ok ? state_next.date_digits : {BCD_W{1'b0}},
                           result_ok ? state_next.time_digits : {BCD_W{1'b0}},
                           status_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_reset_after_line: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> !state_reg.dollar_seen && state_reg.late_fail_mask == '1
            && state_reg.early_error == ST_OK)
        else $error("line state not cleared after last byte");

    a_pos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.dollar_seen |-> state_reg.char_position == '0)
        else $error("position moved before a dollar");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg[4:0] <= ST_LAST)
        else $error("status code out of range");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[4:0] != ST_OK |-> m_data_reg[52:5] == '0)
        else $error("time or date shown with failing status");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg)
        else $error("pending result lost");
`endif

endmodule
